[rtl/ttip_pkg.sv]
// Package for the text-to-integer parser: widths, register map, parse phases
// and the character classification functions.
// No dependencies.
`default_nettype none

package ttip_pkg;

    // Default widths of the parsed value and of the stop offset
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int OFFSET_WIDTH_DEF = 16;

    // Character and register widths
    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 5;
    localparam int DIGIT_W = 5;
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;

    // Register map, as word index (byte address / 4)
    localparam logic REG_BASE = 1'b0;

    // Base after reset
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

    // Marker for a byte that is not a digit
    localparam logic [DIGIT_W-1:0] NOT_DIGIT = DIGIT_W'(16);

    // Parse phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SPACE  = 3'd1,
        PH_START  = 3'd2,
        PH_ZERO   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    // Whitespace: space, TAB, LF, VT, FF, CR
    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Digit value 0 to 15, NOT_DIGIT for anything else
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NOT_DIGIT;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            d = DIGIT_W'(c - 8'h30);
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            d = DIGIT_W'(c - 8'h61 + 8'd10);
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            d = DIGIT_W'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/ttip_stage.sv]
// Register stage with valid/ready handshake for the text-to-integer parser.
// Takes a new word whenever it is empty or its word is being taken.
// No dependencies.
`default_nettype none

module ttip_stage #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    logic         valid_reg;
    logic         valid_next;
    logic [W-1:0] data_reg;

    // Accept when empty or when the held word leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on acceptance
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/ttip_core.sv]
// Parse state and per-byte logic of the text-to-integer parser.
// Depends on ttip_pkg.
`default_nettype none

module ttip_core #(
    parameter int VALUE_WIDTH  = ttip_pkg::VALUE_WIDTH_DEF,
    parameter int OFFSET_WIDTH = ttip_pkg::OFFSET_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    input  wire logic [ttip_pkg::CHAR_W-1:0]     char_in,
    input  wire logic                            first,
    input  wire logic [ttip_pkg::BASE_W-1:0]     base_setting,
    input  wire logic                            res_ready,
    output logic                                 res_valid,
    output logic [VALUE_WIDTH-1:0]               res_value,
    output logic [OFFSET_WIDTH-1:0]              res_offset
);

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};
    localparam logic [ttip_pkg::CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [ttip_pkg::CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [ttip_pkg::CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [ttip_pkg::CHAR_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [ttip_pkg::CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [ttip_pkg::BASE_W-1:0] BASE_AUTO = ttip_pkg::BASE_W'(0);
    localparam logic [ttip_pkg::BASE_W-1:0] BASE_OCT  = ttip_pkg::BASE_W'(8);
    localparam logic [ttip_pkg::BASE_W-1:0] BASE_DEC  = ttip_pkg::BASE_W'(10);
    localparam logic [ttip_pkg::BASE_W-1:0] BASE_HEX  = ttip_pkg::BASE_W'(16);

    ttip_pkg::phase_t              phase_reg, phase_next;
    logic                          negative_reg, negative_next;
    logic [ttip_pkg::BASE_W-1:0]   base_reg, base_next;
    logic [VALUE_WIDTH-1:0]        acc_reg, acc_next;
    logic [OFFSET_WIDTH-1:0]       count_reg, count_next;

    logic                          fire;
    logic                          emit;
    logic                          handled;
    logic                          take;
    logic [ttip_pkg::DIGIT_W-1:0]  digit;
    logic [VALUE_WIDTH-1:0]        acc_cur;
    logic [OFFSET_WIDTH-1:0]       count_cur;

    assign fire  = item_valid && res_ready;
    assign digit = ttip_pkg::digit_of(char_in);

    // Walk the phases for one byte: restart, blanks, sign, prefix, digit
    always_comb
    begin
        phase_next    = first ? ttip_pkg::PH_SPACE : phase_reg;
        negative_next = first ? 1'b0 : negative_reg;
        base_next     = first ? base_setting : base_reg;
        acc_cur       = first ? '0 : acc_reg;
        count_cur     = first ? '0 : count_reg;
        acc_next      = acc_cur;
        take          = 1'b0;
        emit          = 1'b0;
        handled       = (phase_next != ttip_pkg::PH_SPACE) && (phase_next != ttip_pkg::PH_START)
                     && (phase_next != ttip_pkg::PH_ZERO) && (phase_next != ttip_pkg::PH_DIGITS);

        if (!handled && phase_next == ttip_pkg::PH_SPACE)
        begin
            if (ttip_pkg::is_blank(char_in))
            begin
                take    = 1'b1;
                handled = 1'b1;
            end
            else if (char_in == CH_MINUS || char_in == CH_PLUS)
            begin
                negative_next = (char_in == CH_MINUS);
                take          = 1'b1;
                phase_next    = ttip_pkg::PH_START;
                handled       = 1'b1;
            end
            else
            begin
                phase_next = ttip_pkg::PH_START;
            end
        end

        if (!handled && phase_next == ttip_pkg::PH_START)
        begin
            if ((base_next == BASE_AUTO || base_next == BASE_HEX) && char_in == CH_ZERO)
            begin
                take       = 1'b1;
                phase_next = ttip_pkg::PH_ZERO;
                handled    = 1'b1;
            end
            else
            begin
                if (base_next == BASE_AUTO)
                begin
                    base_next = BASE_DEC;
                end
                phase_next = ttip_pkg::PH_DIGITS;
            end
        end

        if (!handled && phase_next == ttip_pkg::PH_ZERO)
        begin
            if (char_in == CH_LOW_X || char_in == CH_UP_X)
            begin
                base_next  = BASE_HEX;
                take       = 1'b1;
                phase_next = ttip_pkg::PH_DIGITS;
                handled    = 1'b1;
            end
            else
            begin
                if (base_next == BASE_AUTO)
                begin
                    base_next = BASE_OCT;
                end
                phase_next = ttip_pkg::PH_DIGITS;
            end
        end

        // Accumulate a digit below the base, otherwise stop and report
        if (!handled)
        begin
            if (digit != ttip_pkg::NOT_DIGIT && digit < base_next)
            begin
                acc_next = acc_cur * VALUE_WIDTH'(base_next) + VALUE_WIDTH'(digit);
                take     = 1'b1;
            end
            else
            begin
                emit       = 1'b1;
                phase_next = ttip_pkg::PH_DONE;
            end
        end

        // Offset saturates at its top value
        count_next = count_cur;
        if (take && count_cur != OFFSET_MAX)
        begin
            count_next = count_cur + 1'b1;
        end
    end

    assign res_valid  = item_valid && emit;
    assign res_value  = negative_next ? (VALUE_WIDTH'(0) - acc_cur) : acc_cur;
    assign res_offset = count_cur;

    // Advance the parse state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ttip_pkg::PH_IDLE;
            negative_reg <= 1'b0;
            base_reg     <= '0;
            acc_reg      <= '0;
            count_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            base_reg     <= base_next;
            acc_reg      <= acc_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/text_to_integer_parser.sv]
// Top level of the text-to-integer parser: APB base register, input stage,
// parse core and result stage.
// Depends on ttip_pkg, ttip_stage and ttip_core.
`default_nettype none

// Parses a byte stream strtol-style: blanks, an optional sign, an optional
// 0x prefix (base 16) or automatic base detection (base 0), then digits.
// One byte is taken per cycle while the result register is not held full by
// m_tready low; each byte passes through an input register and the parse logic
// (a VALUE_WIDTH by 5-bit multiply-add) before its result, if any, lands in the
// output register. s_tuser marks the first byte of a string; the base register
// is latched at that byte and must be written over APB at byte address 0 only
// while the block is idle; the block itself does not enforce this. Each string
// that reaches a stopping byte yields one word on the output: value and the
// offset of the byte that stopped the parse.

module text_to_integer_parser #(
    parameter int VALUE_WIDTH  = ttip_pkg::VALUE_WIDTH_DEF,
    parameter int OFFSET_WIDTH = ttip_pkg::OFFSET_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ttip_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ttip_pkg::APB_W-1:0]    pwdata,
    output logic [ttip_pkg::APB_W-1:0]         prdata,
    output logic                               pready,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ttip_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_in
    input  wire logic                          s_tuser,   // [0] first
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [((VALUE_WIDTH+OFFSET_WIDTH+7)/8)*8-1:0] m_tdata
                                               // value, then stop_offset, zero fill
);

    localparam int TDATA_W = ((VALUE_WIDTH + OFFSET_WIDTH + 7) / 8) * 8;
    localparam int IN_W    = ttip_pkg::CHAR_W + 1;
    localparam int RES_W   = VALUE_WIDTH + OFFSET_WIDTH;

    logic [ttip_pkg::BASE_W-1:0] base_reg;
    logic                        cfg_write;

    logic                        item_valid;
    logic [IN_W-1:0]             item_data;
    logic                        res_ready;
    logic                        res_valid;
    logic [VALUE_WIDTH-1:0]      res_value;
    logic [OFFSET_WIDTH-1:0]     res_offset;
    logic [RES_W-1:0]            out_data;

    // Base register over APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == ttip_pkg::REG_BASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= ttip_pkg::BASE_RESET;
        end
        else if (cfg_write)
        begin
            base_reg <= pwdata[ttip_pkg::BASE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ttip_pkg::REG_BASE)
                  ? ttip_pkg::APB_W'(base_reg) : '0;

    // Input register
    ttip_stage #(
        .W (IN_W)
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   ({s_tuser, s_tdata}),
        .out_valid (item_valid),
        .out_ready (res_ready),
        .out_data  (item_data)
    );

    // Parse logic and state
    ttip_core #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .char_in      (item_data[ttip_pkg::CHAR_W-1:0]),
        .first        (item_data[IN_W-1]),
        .base_setting (base_reg),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res_value    (res_value),
        .res_offset   (res_offset)
    );

    // Result register
    ttip_stage #(
        .W (RES_W)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   ({res_offset, res_value}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = TDATA_W'(out_data);

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench for text_to_integer_parser: drives byte strings and base settings, predicts each
// parsed value and stop offset, and checks every result word against the prediction.
// Depends on ttip_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int VALUE_W  = ttip_pkg::VALUE_WIDTH_DEF;
    localparam int OFFSET_W = ttip_pkg::OFFSET_WIDTH_DEF;
    localparam int RESULT_W = ((VALUE_W + OFFSET_W + 7) / 8) * 8;
    localparam int ADDR_W   = ttip_pkg::ADDR_W;
    localparam int APB_W    = ttip_pkg::APB_W;
    localparam int CHAR_W   = ttip_pkg::CHAR_W;
    localparam int BASE_W   = ttip_pkg::BASE_W;

    // Register address and character codes
    localparam logic [ADDR_W-1:0] BASE_ADDR = ADDR_W'(4 * ttip_pkg::REG_BASE);
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_SPACE = 8'h20;
    // Whitespace set, one byte per slot: space, TAB, LF, VT, FF, CR
    localparam logic [47:0] BLANK_SET = 48'h0D0C0B0A0920;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] offset;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0] pwdata;
    logic [APB_W-1:0] prdata;
    logic pready;
    logic s_tvalid;
    logic s_tready;
    logic [CHAR_W-1:0] s_tdata;     // [7:0] char_in
    logic s_tuser;                  // [0] first
    logic m_tvalid;
    logic m_tready;
    logic [RESULT_W-1:0] m_tdata;   // [31:0] value, [47:32] stop_offset

    // Shadow parser state
    ttip_pkg::phase_t  ph = ttip_pkg::PH_IDLE;
    logic             neg = 1'b0;
    logic [BASE_W-1:0] run_base = '0;
    logic [BASE_W-1:0] base_reg = ttip_pkg::BASE_RESET;
    logic [VALUE_W-1:0] acc = '0;
    logic [OFFSET_W-1:0] cnt = '0;

    parse_result_t pending_results[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic next_first = 1'b0;
    int  bytes_sent = 0;
    int  results_checked = 0;
    int  error_count = 0;

    text_to_integer_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Whitespace test
    function automatic logic ws_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
    endfunction

    // Value of a hex digit, 16 for anything that is not one
    function automatic logic [4:0] hex_digit_val(input logic [7:0] c);
        if (c inside {["0":"9"]})
            return 5'(c - "0");
        if (c inside {["a":"f"]})
            return 5'(c - "a" + 10);
        if (c inside {["A":"F"]})
            return 5'(c - "A" + 10);
        return 5'd16;
    endfunction

    // Character for a digit value, random letter case
    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return 8'("0" + d);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
    endfunction

    // Advance the byte index, saturating
    function automatic void count_byte();
        if (cnt != {OFFSET_W{1'b1}})
            cnt = cnt + 1'b1;
    endfunction

    // Advance the shadow parser by one accepted byte; queue a result at the stop
    task automatic parse_byte(input logic [7:0] c, input logic f);
        logic [4:0] d;
        parse_result_t r;
        if (f)
        begin
            ph = ttip_pkg::PH_SPACE;
            neg = 1'b0;
            run_base = base_reg;
            acc = '0;
            cnt = '0;
        end
        if (!(ph inside {ttip_pkg::PH_SPACE, ttip_pkg::PH_START, ttip_pkg::PH_ZERO,
                         ttip_pkg::PH_DIGITS}))
            return;
        if (ph == ttip_pkg::PH_SPACE)
        begin
            if (ws_char(c))
            begin
                count_byte();
                return;
            end
            if (c == CH_MINUS || c == CH_PLUS)
            begin
                neg = (c == CH_MINUS);
                count_byte();
                ph = ttip_pkg::PH_START;
                return;
            end
            ph = ttip_pkg::PH_START;
        end
        if (ph == ttip_pkg::PH_START)
        begin
            if ((run_base == 0 || run_base == 16) && c == CH_ZERO)
            begin
                count_byte();
                ph = ttip_pkg::PH_ZERO;
                return;
            end
            if (run_base == 0)
                run_base = 5'd10;
            ph = ttip_pkg::PH_DIGITS;
        end
        else if (ph == ttip_pkg::PH_ZERO)
        begin
            if (c == CH_X_LO || c == CH_X_UP)
            begin
                run_base = 5'd16;
                count_byte();
                ph = ttip_pkg::PH_DIGITS;
                return;
            end
            if (run_base == 0)
                run_base = 5'd8;
            ph = ttip_pkg::PH_DIGITS;
        end
        d = hex_digit_val(c);
        if (d < 16 && d < run_base)
        begin
            acc = acc * VALUE_W'(run_base) + VALUE_W'(d);
            count_byte();
            return;
        end
        r.value = neg ? -acc : acc;
        r.offset = cnt;
        pending_results.push_back(r);
        ph = ttip_pkg::PH_DONE;
    endtask

    // Offer one byte, with random idle cycles ahead of it, and hold until taken
    task automatic send_char(input logic [7:0] c);
        logic rdy;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= next_first;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        parse_byte(c, next_first);
        next_first = 1'b0;
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Drop valid, wait for every expected word, then let the pipeline empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write the base register while idle and read it back
    task automatic write_base(input logic [BASE_W-1:0] b);
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= BASE_ADDR;
        pwdata  <= APB_W'(b);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        base_reg = b;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== APB_W'(base_reg))
        begin
            $error("base_setting readback: expected %0d, actual %0d", base_reg, prdata);
            error_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    // Blanks, sign, prefix and digits valid for the base, then a NUL or random byte and trailing bytes
    task automatic send_number_text(input logic [BASE_W-1:0] b);
        int radix;
        int n;
        int pick;
        next_first = 1'b1;
        repeat ($urandom_range(0, 3)) send_char(BLANK_SET[8 * $urandom_range(0, 5) +: 8]);
        pick = $urandom_range(0, 2);
        if (pick == 1)
            send_char(CH_PLUS);
        else if (pick == 2)
            send_char(CH_MINUS);
        radix = (b > 16) ? 16 : b;
        if (b == 0)
        begin
            pick = $urandom_range(0, 2);
            if (pick == 0)
            begin
                send_char(CH_ZERO);
                send_char($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
                radix = 16;
            end
            else if (pick == 1)
            begin
                send_char(CH_ZERO);
                radix = 8;
            end
            else
                radix = 10;
        end
        else if (b == 16 && $urandom_range(0, 1))
        begin
            send_char(CH_ZERO);
            send_char($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
        end
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++)
        begin
            if (b == 0 && radix == 10 && i == 0)
                send_char(digit_char($urandom_range(1, 9)));
            else
                send_char(digit_char($urandom_range(0, radix - 1)));
        end
        send_char($urandom_range(0, 1) ? CH_NUL : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)));
    endtask

    // Random bytes with string starts scattered through them
    task automatic send_noise();
        next_first = 1'b1;
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 4) == 0)
                next_first = 1'b1;
            send_char(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_directed();
        set_idle(0);
        // byte before any string start
        next_first = 1'b0;
        send_char("5");
        // blank, minus sign, digits, NUL
        next_first = 1'b1;
        send_text("\t-12");
        send_char(CH_NUL);
        // byte after the stop
        send_char("3");
        // restart while a parse is running, then a stop with no digits
        next_first = 1'b1;
        send_text("+9");
        next_first = 1'b1;
        send_char(8'hFF);
        // automatic base: hex prefix, then prefix with no hex digit
        write_base(5'd0);
        next_first = 1'b1;
        send_text("0x1fZ");
        next_first = 1'b1;
        send_text("0xg");
        // base 16 with upper-case prefix and digits
        write_base(5'd16);
        next_first = 1'b1;
        send_text("0XfF");
        send_char(CH_NUL);
    endtask

    task automatic test_random_strings();
        int base_list[8];
        int target;
        logic [BASE_W-1:0] b;
        base_list = '{0, 1, 2, 8, 10, 16, 17, 31};
        for (int mode = 0; mode < 4; mode++)
        begin
            for (int k = 0; k < 6; k++)
            begin
                set_idle(mode);
                b = BASE_W'(base_list[(mode * 6 + k) % 8]);
                write_base(b);
                target = bytes_sent + 75;
                while (bytes_sent < target)
                begin
                    if ($urandom_range(0, 99) < 85)
                        send_number_text(b);
                    else
                        send_noise();
                end
            end
        end
    endtask

    // Receiver stalls
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each accepted result word with the oldest prediction
    always @(negedge clk)
    begin
        parse_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result word with no prediction waiting: %h", m_tdata);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tdata[VALUE_W-1:0] !== exp_r.value)
                begin
                    $error("value: expected %0d, actual %0d", $signed(exp_r.value),
                           $signed(m_tdata[VALUE_W-1:0]));
                    error_count++;
                end
                if (m_tdata[VALUE_W +: OFFSET_W] !== exp_r.offset)
                begin
                    $error("stop_offset: expected %0d, actual %0d", exp_r.offset,
                           m_tdata[VALUE_W +: OFFSET_W]);
                    error_count++;
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        m_tready <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_strings();
        drain_results();

        $display("Parsed %0d input bytes over bases 0 to 31 with four idling mixes,", bytes_sent);
        $display("covering blanks, signs, prefixes and restarts: %0d result words checked, %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
